/* src/tli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

   // Command codes carried by req_command.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_INTERP     = 2'd0;
   localparam logic [1:0] STATUS_EXACT      = 2'd1;
   localparam logic [1:0] STATUS_CLAMP_HIGH = 2'd2;
   localparam logic [1:0] STATUS_CLAMP_LOW  = 2'd3;

   // Field widths fixed by the interface.
   localparam int ENERGY_W  = 32;
   localparam int SECTION_W = 32;
   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;

   // Number of entries searched after reset.
   localparam logic [COUNT_W-1:0] RESET_ENTRIES = 7'd49;

   // Query sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_MULT,
      S_DIV,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

/* src/table_linear_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                                     Handshake
// request   req_command req_entry_index req_energy req_cross_section  start, busy
// response  rsp_value rsp_status                                      rsp_valid strobe
// csr       csr_data                                                  csr_valid, csr_ready
//
// A load transaction writes the table in the accept cycle and leaves busy low.
// A query reads one table entry at a time, through a fetch state and then a
// check state (the single registered memory read port sets this); an
// interpolation then adds one multiply, 32 divider steps and one add; busy
// drops with the strobe.
// Reset clears control state only; table entries are undefined until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module table_linear_interpolator
   import tli_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire                  req_command,
   input  wire  [INDEX_W-1:0]   req_entry_index,
   input  wire  [ENERGY_W-1:0]  req_energy,
   input  wire  [SECTION_W-1:0] req_cross_section,
   output logic                 rsp_valid,
   output logic [SECTION_W-1:0] rsp_value,
   output logic [1:0]           rsp_status,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [COUNT_W-1:0]   csr_data
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int LW     = IDX_W + INDEX_W;
   localparam int WORD_W = ENERGY_W + SECTION_W;
   localparam int PROD_W = ENERGY_W + SECTION_W;
   localparam int STEP_W = $clog2(ENERGY_W);

   // Registers.
   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     entries_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       last_ff, last_in;
   logic [ENERGY_W-1:0]    query_ff, query_in;
   logic [ENERGY_W-1:0]    hi_energy_ff, hi_energy_in;
   logic [SECTION_W-1:0]   hi_section_ff, hi_section_in;
   logic [ENERGY_W-1:0]    dx_ff, dx_in;
   logic [SECTION_W-1:0]   dv_ff, dv_in;
   logic [ENERGY_W-1:0]    span_ff, span_in;
   logic                   rising_ff, rising_in;
   logic [SECTION_W-1:0]   base_ff, base_in;
   logic [ENERGY_W-1:0]    rem_ff, rem_in;
   logic [SECTION_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SECTION_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]      rd_data_ff;

   // Table memory: energy in the upper half, cross section in the lower half.
   logic [WORD_W-1:0]      table_mem [TABLE_DEPTH];

   logic                   accept;
   logic [LW-1:0]          load_wide;
   logic                   load_en;
   logic [CW-1:0]          count_w;
   logic [CW-1:0]          count_sat;
   logic [ENERGY_W-1:0]    rd_energy;
   logic [SECTION_W-1:0]   rd_section;
   logic [PROD_W-1:0]      product;
   logic [ENERGY_W:0]      trial;
   logic                   take;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign rd_energy  = rd_data_ff[WORD_W-1:SECTION_W];
   assign rd_section = rd_data_ff[SECTION_W-1:0];

   // A load whose index lies beyond the table is dropped.
   assign load_wide = LW'(req_entry_index);
   assign load_en   = accept && (req_command == CMD_LOAD) && (load_wide < LW'(TABLE_DEPTH));

   // Clamp the searched entry count into the legal range.
   always_comb begin
      count_w = CW'(entries_ff);
      if (count_w < CW'(2)) begin
         count_sat = CW'(2);
      end else if (count_w > CW'(TABLE_DEPTH)) begin
         count_sat = CW'(TABLE_DEPTH);
      end else begin
         count_sat = count_w;
      end
   end

   // One multiplier and one restoring divider step.
   assign product = PROD_W'(dx_ff) * PROD_W'(dv_ff);
   assign trial   = {rem_ff, quo_ff[SECTION_W-1]};
   assign take    = (trial >= {1'b0, span_ff});

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (load_en) begin
         table_mem[load_wide[IDX_W-1:0]] <= {req_energy, req_cross_section};
      end
      rd_data_ff <= table_mem[idx_ff];
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= RESET_ENTRIES;
      end else if (csr_valid && csr_ready) begin
         entries_ff <= csr_data;
      end
   end

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      query_ff      <= query_in;
      hi_energy_ff  <= hi_energy_in;
      hi_section_ff <= hi_section_in;
      dx_ff         <= dx_in;
      dv_ff         <= dv_in;
      span_ff       <= span_in;
      rising_ff     <= rising_in;
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      query_in      = query_ff;
      hi_energy_in  = hi_energy_ff;
      hi_section_in = hi_section_ff;
      dx_in         = dx_ff;
      dv_in         = dv_ff;
      span_in       = span_ff;
      rising_in     = rising_ff;
      base_in       = base_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            // A query transaction starts the walk at entry 0.
            if (accept && (req_command == CMD_QUERY)) begin
               query_in = req_energy;
               last_in  = IDX_W'(count_sat - CW'(1));
               idx_in   = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((idx_ff == '0) && (query_ff > rd_energy)) begin
               // Above the first entry: clamp to it.
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_section;
               rsp_status_in = STATUS_CLAMP_HIGH;
               state_in      = S_IDLE;
            end else if (query_ff == rd_energy) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_section;
               rsp_status_in = STATUS_EXACT;
               state_in      = S_IDLE;
            end else if ((idx_ff != '0) && (query_ff > rd_energy)) begin
               // Bracketed between this entry and the previous one.
               dx_in     = query_ff - rd_energy;
               span_in   = hi_energy_ff - rd_energy;
               rising_in = (hi_section_ff >= rd_section);
               dv_in     = (hi_section_ff >= rd_section) ? (hi_section_ff - rd_section)
                                                         : (rd_section - hi_section_ff);
               base_in   = rd_section;
               state_in  = S_MULT;
            end else if (idx_ff == last_ff) begin
               // Below the last searched entry: clamp to it.
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_section;
               rsp_status_in = STATUS_CLAMP_LOW;
               state_in      = S_IDLE;
            end else begin
               hi_energy_in  = rd_energy;
               hi_section_in = rd_section;
               idx_in        = idx_ff + IDX_W'(1);
               state_in      = S_FETCH;
            end
         end
         S_MULT: begin
            // The upper product half is below the span, so the quotient fits 32 bits.
            rem_in   = product[PROD_W-1:SECTION_W];
            quo_in   = product[SECTION_W-1:0];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = take ? ENERGY_W'(trial - {1'b0, span_ff}) : ENERGY_W'(trial);
            quo_in  = {quo_ff[SECTION_W-2:0], take};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ENERGY_W - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rising_ff ? (base_ff + quo_ff) : (base_ff - quo_ff);
            rsp_status_in = STATUS_INTERP;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // A result strobe never lasts more than one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // An accepted query begins its walk at entry 0.
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_QUERY)) |=> (state_ff == S_FETCH) && (idx_ff == '0))
      else $error("query did not start at entry 0");

   // The divider remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder out of range");

   // Results come only from a decision or the end of an interpolation.
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (($past(state_ff) == S_CHECK) || ($past(state_ff) == S_FINISH)))
      else $error("result strobe from an unexpected state");

   // The walk never passes the last searched entry.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (idx_ff <= last_ff))
      else $error("table walk ran past the last entry");
`endif

endmodule

`default_nettype wire

/* verif/table_linear_interpolator_tb.sv */
`timescale 1ns / 1ps

module table_linear_interpolator_tb;
   import tli_pkg::*;

   localparam int DEPTH         = 64;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int PHASES        = 9;
   localparam int MAX_REPORTS   = 10;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      logic [SECTION_W-1:0] value;
      logic [1:0]           status;
   } xs_result_type;

   typedef struct packed {
      logic                 command;
      logic [INDEX_W-1:0]   index;
      logic [ENERGY_W-1:0]  energy;
      logic [SECTION_W-1:0] section;
      logic                 known;
      logic [SECTION_W-1:0] exp_value;
      logic [1:0]           exp_status;
   } directed_row_type;

   // Directed rows. The count is 4 while these run, so entries 0..3 are searched.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Descending table with extreme values.
      '{CMD_LOAD,  6'd0, 32'hFFFF_F000, 32'd1000,      1'b0, 32'd0,         STATUS_INTERP},
      '{CMD_LOAD,  6'd1, 32'h8000_0000, 32'd0,         1'b0, 32'd0,         STATUS_INTERP},
      '{CMD_LOAD,  6'd2, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0, 32'd0,         STATUS_INTERP},
      '{CMD_LOAD,  6'd3, 32'h0000_0001, 32'h1234_5678, 1'b0, 32'd0,         STATUS_INTERP},
      // Above, on and below the ends, and exact hits inside.
      '{CMD_QUERY, 6'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd1000,      STATUS_CLAMP_HIGH},
      '{CMD_QUERY, 6'd0, 32'hFFFF_F000, 32'd0, 1'b1, 32'd1000,      STATUS_EXACT},
      '{CMD_QUERY, 6'd0, 32'h8000_0000, 32'd0, 1'b1, 32'd0,         STATUS_EXACT},
      '{CMD_QUERY, 6'd0, 32'h0000_0001, 32'd0, 1'b1, 32'h1234_5678, STATUS_EXACT},
      '{CMD_QUERY, 6'd0, 32'h0000_0000, 32'd0, 1'b1, 32'h1234_5678, STATUS_CLAMP_LOW},
      // Interpolation on rising and falling segments.
      '{CMD_QUERY, 6'd0, 32'h8000_0001, 32'd0, 1'b0, 32'd0, STATUS_INTERP},
      '{CMD_QUERY, 6'd0, 32'h4000_0000, 32'd0, 1'b0, 32'd0, STATUS_INTERP},
      '{CMD_QUERY, 6'd0, 32'h0000_0002, 32'd0, 1'b0, 32'd0, STATUS_INTERP},
      // Full-scale segment, largest product.
      '{CMD_LOAD,  6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, STATUS_INTERP},
      '{CMD_LOAD,  6'd1, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0, STATUS_INTERP},
      '{CMD_QUERY, 6'd0, 32'hFFFF_FFFE, 32'd0, 1'b0, 32'd0,         STATUS_INTERP},
      '{CMD_QUERY, 6'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'hFFFF_FFFF, STATUS_EXACT},
      '{CMD_QUERY, 6'd0, 32'h0000_0000, 32'd0, 1'b1, 32'd0,         STATUS_EXACT},
      // Table that is not descending.
      '{CMD_LOAD,  6'd0, 32'd100, 32'd10, 1'b0, 32'd0, STATUS_INTERP},
      '{CMD_LOAD,  6'd1, 32'd200, 32'd7,  1'b0, 32'd0, STATUS_INTERP},
      '{CMD_LOAD,  6'd2, 32'd50,  32'd0,  1'b0, 32'd0, STATUS_INTERP},
      '{CMD_QUERY, 6'd0, 32'd150, 32'd0,  1'b1, 32'd10, STATUS_CLAMP_HIGH},
      '{CMD_QUERY, 6'd0, 32'd80,  32'd0,  1'b0, 32'd0,  STATUS_INTERP}
   };

   // Counts used by the random phases; the last phase picks its own.
   localparam logic [COUNT_W-1:0] COUNT_PLAN [PHASES-1] = '{
      7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd65, 7'd33, 7'd49
   };

   logic                 clock;
   logic                 reset;
   logic                 start;
   wire                  busy;
   logic                 req_command;
   logic [INDEX_W-1:0]   req_entry_index;
   logic [ENERGY_W-1:0]  req_energy;
   logic [SECTION_W-1:0] req_cross_section;
   wire                  rsp_valid;
   wire  [SECTION_W-1:0] rsp_value;
   wire  [1:0]           rsp_status;
   logic                 csr_valid;
   wire                  csr_ready;
   logic [COUNT_W-1:0]   csr_data;

   // Shadow table, search count and results still owed by the block.
   logic [ENERGY_W-1:0]  shadow_energy [DEPTH];
   logic [SECTION_W-1:0] shadow_section [DEPTH];
   logic [COUNT_W-1:0]   shadow_count;
   xs_result_type        owed_results [$];

   int  error_count;
   int  cycle_count;
   int  loads_sent;
   int  queries_sent;
   int  counts_used;
   int  status_seen [4];
   bit  bursty;
   int  burst_left;

   table_linear_interpolator #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_energy        (req_energy),
      .req_cross_section (req_cross_section),
      .rsp_valid         (rsp_valid),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Straight line between two entries, unsigned math on magnitudes, quotient truncated toward zero.
   function automatic logic [SECTION_W-1:0] lerp_section(
      input logic [ENERGY_W-1:0]  e_query,
      input logic [ENERGY_W-1:0]  e_lo,
      input logic [ENERGY_W-1:0]  e_hi,
      input logic [SECTION_W-1:0] v_lo,
      input logic [SECTION_W-1:0] v_hi
   );
      logic [63:0] dx;
      logic [63:0] span;
      logic [63:0] dv;
      logic [63:0] quotient;
      logic        rising;
      dx       = {32'd0, e_query} - {32'd0, e_lo};
      span     = {32'd0, e_hi} - {32'd0, e_lo};
      rising   = (v_hi >= v_lo);
      dv       = rising ? {32'd0, v_hi - v_lo} : {32'd0, v_lo - v_hi};
      quotient = (dx * dv) / span;
      return rising ? v_lo + quotient[31:0] : v_lo - quotient[31:0];
   endfunction

   function automatic int searched_entries(input logic [COUNT_W-1:0] count);
      if (count < 2)
         return 2;
      if (count > DEPTH)
         return DEPTH;
      return int'(count);
   endfunction

   // Cross section the block should return for a query energy.
   function automatic xs_result_type predict_section(input logic [ENERGY_W-1:0] e);
      xs_result_type res;
      int            n;
      n = searched_entries(shadow_count);
      if (e > shadow_energy[0]) begin
         res.value  = shadow_section[0];
         res.status = STATUS_CLAMP_HIGH;
      end else if (e == shadow_energy[0]) begin
         res.value  = shadow_section[0];
         res.status = STATUS_EXACT;
      end else begin
         res.value  = shadow_section[n-1];
         res.status = STATUS_CLAMP_LOW;
         for (int i = 1; i < n; i++) begin
            if (e == shadow_energy[i]) begin
               res.value  = shadow_section[i];
               res.status = STATUS_EXACT;
               break;
            end
            if (e > shadow_energy[i]) begin
               res.value  = lerp_section(e, shadow_energy[i], shadow_energy[i-1],
                                         shadow_section[i], shadow_section[i-1]);
               res.status = STATUS_INTERP;
               break;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [SECTION_W-1:0] random_section();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Query energy aimed at a region of the current table.
   function automatic logic [ENERGY_W-1:0] query_energy(input int n);
      int k;
      k = $urandom_range(1, n - 1);
      case ($urandom_range(0, 9))
         0, 1:    return shadow_energy[$urandom_range(0, n - 1)];
         2:       return $urandom_range(32'hFFFF_FFFF, shadow_energy[0]);
         3:       return $urandom_range(shadow_energy[n-1], 0);
         4:       return $urandom;
         5:       return shadow_energy[k] + 32'd1;
         default: return $urandom_range(shadow_energy[k-1], shadow_energy[k]);
      endcase
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
   endtask

   // Drives one transaction on the request channel and predicts its outcome
   // at the edge that accepts it. Start stays high into the next transaction
   // unless a gap is due.
   task automatic send_item(
      input logic                 cmd,
      input logic [INDEX_W-1:0]   idx,
      input logic [ENERGY_W-1:0]  e,
      input logic [SECTION_W-1:0] cs,
      input logic                 known,
      input xs_result_type        typed
   );
      int gap;
      gap = 0;
      if (bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : $urandom_range(1, 6);
         end
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start             <= 1'b1;
      req_command       <= cmd;
      req_entry_index   <= idx;
      req_energy        <= e;
      req_cross_section <= cs;
      do @(posedge clock); while (busy);
      if (cmd == CMD_LOAD) begin
         shadow_energy[idx]  = e;
         shadow_section[idx] = cs;
         loads_sent++;
      end else begin
         owed_results.push_back(known ? typed : predict_section(e));
         queries_sent++;
      end
   endtask

   // Writes the entry count once the block has drained.
   task automatic write_entry_count(input logic [COUNT_W-1:0] count);
      @(negedge clock);
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      shadow_count = count;
      counts_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random phase: load a fresh descending table, then mix queries with
   // entry rewrites that may break the ordering.
   task automatic run_phase(input logic [COUNT_W-1:0] count, input int budget);
      int                  n;
      int                  sent;
      int                  idx;
      logic [ENERGY_W-1:0] top;
      logic [ENERGY_W-1:0] step_max;
      logic [ENERGY_W-1:0] e;
      n          = searched_entries(count);
      bursty     = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      case ($urandom_range(0, 3))
         0:       top = 32'hFFFF_FFFF;
         1:       top = $urandom_range(n, 4096);
         default: top = $urandom | 32'h8000_0000;
      endcase
      step_max = top / n;
      if ($urandom_range(0, 2) == 0 && step_max > 16)
         step_max = 16;
      e = top;
      for (int i = 0; i < n; i++) begin
         send_item(CMD_LOAD, INDEX_W'(i), e, random_section(), 1'b0, '0);
         if (i < n - 1)
            e = e - $urandom_range(1, step_max);
      end
      sent = n;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 20) begin
            idx = $urandom_range(0, DEPTH - 1);
            e   = ($urandom_range(0, 1) == 0) ? shadow_energy[idx] : $urandom;
            send_item(CMD_LOAD, INDEX_W'(idx), e, random_section(), 1'b0, '0);
         end else begin
            send_item(CMD_QUERY, INDEX_W'($urandom), query_energy(n), $urandom, 1'b0, '0);
         end
         sent++;
      end
   endtask

   // Result checker: every strobe must match the oldest owed result.
   always @(posedge clock) begin
      xs_result_type want;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            log_error($sformatf("result with nothing owed: value 0x%08h status %0d",
                                rsp_value, rsp_status));
         end else begin
            want = owed_results.pop_front();
            if (rsp_value !== want.value)
               log_error($sformatf("value mismatch: expected 0x%08h, got 0x%08h",
                                   want.value, rsp_value));
            if (rsp_status !== want.status)
               log_error($sformatf("status mismatch: expected %0d, got %0d",
                                   want.status, rsp_status));
            else
               status_seen[want.status]++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, owed_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [COUNT_W-1:0] count;
      xs_result_type      typed;
      clock             = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_command       = CMD_LOAD;
      req_entry_index   = '0;
      req_energy        = '0;
      req_cross_section = '0;
      csr_valid         = 1'b0;
      csr_data          = '0;
      shadow_count      = RESET_ENTRIES;
      error_count       = 0;
      cycle_count       = 0;
      loads_sent        = 0;
      queries_sent      = 0;
      counts_used       = 0;
      status_seen       = '{0, 0, 0, 0};
      bursty            = 1'b1;
      burst_left        = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows on a four-entry search.
      write_entry_count(7'd4);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         typed.value  = DIRECTED[r].exp_value;
         typed.status = DIRECTED[r].exp_status;
         send_item(DIRECTED[r].command, DIRECTED[r].index, DIRECTED[r].energy,
                   DIRECTED[r].section, DIRECTED[r].known, typed);
      end

      // Random phases over several entry counts, the extremes among them.
      for (int p = 0; p < PHASES; p++) begin
         count = (p < PHASES - 1) ? COUNT_PLAN[p] : COUNT_W'($urandom_range(0, 127));
         write_entry_count(count);
         run_phase(count, RANDOM_ITEMS / PHASES);
      end

      @(negedge clock);
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d loads and %0d queries across %0d entry-count settings.",
               loads_sent, queries_sent, counts_used);
      $display("Results seen: %0d interpolated, %0d exact, %0d clamped high, %0d clamped low.",
               status_seen[STATUS_INTERP], status_seen[STATUS_EXACT],
               status_seen[STATUS_CLAMP_HIGH], status_seen[STATUS_CLAMP_LOW]);
      if (error_count == 0 && owed_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d errors, %0d results never arrived.", error_count, owed_results.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
